FILE: hw/rtl/grle_pkg.sv
// Shared types and codes for the grayscale run-length decoder.
package grle_pkg;

	localparam int unsigned PosW = 28;
	localparam int unsigned AccW = 24;

	localparam logic [1:0] OP_BLACK = 2'b00;
	localparam logic [1:0] OP_GRAY  = 2'b01;
	localparam logic [1:0] OP_DELTA = 2'b10;
	localparam logic [1:0] OP_WHITE = 2'b11;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_ZERO_RUN  = 2'd1;
	localparam logic [1:0] ERR_PAST_END  = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED = 2'd3;

	localparam logic [7:0] NIB_MASK   = 8'h0F;
	localparam logic [7:0] WHITE_VAL  = 8'hFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} grle_byte_t;

	typedef struct packed {
		logic [7:0]      gray_value;
		logic [PosW-1:0] run_length;
		logic [PosW-1:0] run_start;
		logic [1:0]      error_code;
	} grle_run_t;

	typedef struct packed {
		logic [1:0]      error_code;
		logic [PosW-1:0] next_pos;
	} grle_eval_t;

endpackage

FILE: hw/rtl/grle_ifs.sv
// Channel interfaces: encoded bytes in, runs out, image size write.
interface grle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface grle_run_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                gray_value;
	logic [grle_pkg::PosW-1:0] run_length;
	logic [grle_pkg::PosW-1:0] run_start;
	logic [1:0]                error_code;

	modport source (output valid, gray_value, run_length, run_start, error_code, input ready);
	modport sink   (input valid, gray_value, run_length, run_start, error_code, output ready);
endinterface

interface grle_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [grle_pkg::PosW-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/grle_run_eval.sv
// Run checks: zero length, overrun of the image, and the next pixel position.
module grle_run_eval (
	input  logic [grle_pkg::PosW-1:0] start,
	input  logic [grle_pkg::PosW-1:0] length,
	input  logic [grle_pkg::PosW-1:0] image_pixels,
	output grle_pkg::grle_eval_t      eval
);

	logic [grle_pkg::PosW:0] end_pos;

	assign end_pos = {1'b0, start} + {1'b0, length};

	always_comb begin
		if (length == '0) begin
			eval.error_code = grle_pkg::ERR_ZERO_RUN;
			eval.next_pos   = start;
		end else if (end_pos > {1'b0, image_pixels}) begin
			eval.error_code = grle_pkg::ERR_PAST_END;
			eval.next_pos   = image_pixels;
		end else begin
			eval.error_code = grle_pkg::ERR_OK;
			eval.next_pos   = end_pos[grle_pkg::PosW-1:0];
		end
	end

endmodule

FILE: hw/rtl/grle_parser.sv
// Chunk parser: per-byte parse state update and the registered run result.
module grle_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  grle_pkg::grle_byte_t      item,
	input  logic [grle_pkg::PosW-1:0] image_pixels,
	input  logic                      out_ready,
	output logic                      out_valid,
	output grle_pkg::grle_run_t       out_run
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_GRAY = 3'd1,
		PH_LEN1 = 3'd2,
		PH_LEN2 = 3'd3,
		PH_LEN3 = 3'd4
	} phase_t;

	phase_t                      phase_q, phase_n, phase_eff;
	logic [7:0]                  header_q, header_n;
	logic [7:0]                  gray_q, gray_n, gray_eff;
	logic [grle_pkg::AccW-1:0]   acc_q, acc_n, acc_eff;
	logic [7:0]                  prev_q, prev_n, prev_eff;
	logic [grle_pkg::PosW-1:0]   pos_q, pos_n, pos_eff;
	logic                        emit;
	logic [7:0]                  run_val;
	logic [grle_pkg::PosW-1:0]   run_len;
	grle_pkg::grle_eval_t        eval;
	grle_pkg::grle_run_t         res;
	logic                        res_valid;
	logic                        out_valid_q;
	grle_pkg::grle_run_t         out_q;

	// operand field = number of length bytes still to come
	function automatic phase_t len_phase(input logic [1:0] sel);
		phase_t ph;
		begin
			case (sel)
				2'd1:    ph = PH_LEN1;
				2'd2:    ph = PH_LEN2;
				default: ph = PH_LEN3;
			endcase
			return ph;
		end
	endfunction

	grle_run_eval u_eval (
		.start        (pos_eff),
		.length       (run_len),
		.image_pixels (image_pixels),
		.eval         (eval)
	);

	always_comb begin
		logic [7:0] b;
		logic [1:0] op;
		logic [1:0] sel;
		logic [3:0] nib;
		logic [7:0] hdr_nib;
		b       = item.data_byte;
		op      = b[7:6];
		sel     = b[5:4];
		nib     = b[3:0];
		hdr_nib = header_q & grle_pkg::NIB_MASK;

		// layer start clears the parse context before the byte is parsed
		phase_eff = item.first_byte ? PH_IDLE : phase_q;
		gray_eff  = item.first_byte ? 8'd0 : gray_q;
		acc_eff   = item.first_byte ? '0 : acc_q;
		prev_eff  = item.first_byte ? 8'd0 : prev_q;
		pos_eff   = item.first_byte ? '0 : pos_q;

		phase_n  = phase_eff;
		header_n = header_q;
		gray_n   = gray_eff;
		acc_n    = acc_eff;
		emit     = 1'b0;
		run_val  = gray_eff;
		run_len  = '0;

		case (phase_eff)
			PH_GRAY: begin
				gray_n  = b;
				acc_n   = '0;
				run_val = b;
				if (header_q[5:4] == 2'd0) begin
					emit    = 1'b1;
					run_len = {{(grle_pkg::PosW-8){1'b0}}, hdr_nib};
				end else begin
					phase_n = len_phase(header_q[5:4]);
				end
			end
			PH_LEN1: begin
				acc_n   = {acc_eff[grle_pkg::AccW-9:0], b};
				emit    = 1'b1;
				run_val = gray_eff;
				if (header_q[7:6] == grle_pkg::OP_DELTA) begin
					run_len = {{(grle_pkg::PosW-grle_pkg::AccW){1'b0}}, acc_n};
				end else begin
					run_len = {acc_n, hdr_nib[3:0]};
				end
			end
			PH_LEN2: begin
				acc_n   = {acc_eff[grle_pkg::AccW-9:0], b};
				phase_n = PH_LEN1;
			end
			PH_LEN3: begin
				acc_n   = {acc_eff[grle_pkg::AccW-9:0], b};
				phase_n = PH_LEN2;
			end
			default: begin
				header_n = b;
				acc_n    = '0;
				phase_n  = PH_IDLE;
				case (op)
					grle_pkg::OP_DELTA: begin
						gray_n  = sel[1] ? (prev_eff - {4'd0, nib}) : (prev_eff + {4'd0, nib});
						run_val = gray_n;
						if (sel[0]) begin
							phase_n = PH_LEN1;
						end else begin
							emit    = 1'b1;
							run_len = {{(grle_pkg::PosW-1){1'b0}}, 1'b1};
						end
					end
					grle_pkg::OP_GRAY: begin
						phase_n = PH_GRAY;
					end
					default: begin
						gray_n  = (op == grle_pkg::OP_BLACK) ? 8'd0 : grle_pkg::WHITE_VAL;
						run_val = gray_n;
						if (sel == 2'd0) begin
							emit    = 1'b1;
							run_len = {{(grle_pkg::PosW-4){1'b0}}, nib};
						end else begin
							phase_n = len_phase(sel);
						end
					end
				endcase
			end
		endcase

		pos_n  = pos_eff;
		prev_n = prev_eff;
		res.gray_value  = run_val;
		res.run_length  = run_len;
		res.run_start   = pos_eff;
		res.error_code  = eval.error_code;
		res_valid       = emit;
		if (emit) begin
			phase_n = PH_IDLE;
			pos_n   = eval.next_pos;
			if (eval.error_code != grle_pkg::ERR_ZERO_RUN) begin
				prev_n = run_val;
			end
		end else if (item.last_byte && phase_n != PH_IDLE) begin
			// chunk cut short by the end of the layer
			res.gray_value  = 8'd0;
			res.run_length  = '0;
			res.run_start   = pos_eff;
			res.error_code  = grle_pkg::ERR_TRUNCATED;
			res_valid       = 1'b1;
			phase_n         = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			header_q    <= '0;
			gray_q      <= '0;
			acc_q       <= '0;
			prev_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			header_q    <= header_n;
			gray_q      <= gray_n;
			acc_q       <= acc_n;
			prev_q      <= prev_n;
			pos_q       <= pos_n;
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_run   = out_q;

endmodule

FILE: hw/rtl/gray_rle_run_decoder.sv
// Top level of the grayscale run-length decoder with delta mode.
//
// enc carries the encoded layer image one byte per item; first_byte marks
// the first byte of a layer and restarts pixel position and previous value,
// last_byte marks the final byte. run carries one result per chunk:
// gray value, length, start pixel and an error code (zero run, past image
// end, truncated chunk). cfg writes image_pixels; write it while idle.
// A run appears on run once the byte that closes its chunk has passed the
// input register and then the result register.
// Throughput: one byte per cycle while run is not stalled; the parse state
// update is combinational logic between the input and result registers.
// Reset clears the parse state, image_pixels and both register valid flags.
// When run stalls, the held result stays put, a byte is taken into the input
// register only if it is empty, and enc.ready is low until run drains.
module gray_rle_run_decoder (
	input logic       clk,
	input logic       arst_n,
	grle_byte_if.sink enc,
	grle_run_if.source run,
	grle_cfg_if.sink  cfg
);

	logic                      byte_valid_s1;
	grle_pkg::grle_byte_t      byte_s1;
	logic [grle_pkg::PosW-1:0] image_pixels_q;
	logic                      out_free;
	logic                      step;
	logic                      out_valid;
	grle_pkg::grle_run_t       out_run;

	assign out_free  = !out_valid || run.ready;
	assign step      = byte_valid_s1 && out_free;
	assign enc.ready = !byte_valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1  <= 1'b0;
			image_pixels_q <= '0;
		end else begin
			if (enc.ready) begin
				byte_valid_s1 <= enc.valid;
			end
			if (cfg.valid) begin
				image_pixels_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc.valid && enc.ready) begin
			byte_s1 <= '{data_byte: enc.data_byte, first_byte: enc.first_byte,
				last_byte: enc.last_byte};
		end
	end

	grle_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item         (byte_s1),
		.image_pixels (image_pixels_q),
		.out_ready    (run.ready),
		.out_valid    (out_valid),
		.out_run      (out_run)
	);

	assign run.valid       = out_valid;
	assign run.gray_value  = out_run.gray_value;
	assign run.run_length  = out_run.run_length;
	assign run.run_start   = out_run.run_start;
	assign run.error_code  = out_run.error_code;

endmodule

FILE: hw/rtl/grle_checker.sv
// Port-level checks for the run decoder, bound to the top level.
module grle_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      enc_valid,
	input logic                      enc_ready,
	input logic                      run_valid,
	input logic                      run_ready,
	input logic [7:0]                gray_value,
	input logic [grle_pkg::PosW-1:0] run_length,
	input logic [1:0]                error_code,
	input logic                      cfg_ready
);

	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid)
		else $error("run item dropped while stalled");

	a_trunc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && error_code == grle_pkg::ERR_TRUNCATED |->
		gray_value == 8'd0 && run_length == '0)
		else $error("truncated chunk carries a value or length");

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && error_code != grle_pkg::ERR_TRUNCATED |->
		((run_length == '0) == (error_code == grle_pkg::ERR_ZERO_RUN)))
		else $error("zero run flag disagrees with run length");

	a_run_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(run_valid) |-> $past(enc_valid && enc_ready, 2))
		else $error("run item without a byte two cycles earlier");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind gray_rle_run_decoder grle_checker u_grle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.enc_valid   (enc.valid),
	.enc_ready   (enc.ready),
	.run_valid   (run.valid),
	.run_ready   (run.ready),
	.gray_value  (run.gray_value),
	.run_length  (run.run_length),
	.error_code  (run.error_code),
	.cfg_ready   (cfg.ready)
);
